### design/swv_pkg.sv
// Shared types, codes and tables for the square-wave voice.
package swv_pkg;

  typedef enum logic [2:0] {
    KindRegWrite = 3'd0,
    KindEnable   = 3'd1,
    KindTick     = 3'd2,
    KindQuarter  = 3'd3,
    KindHalf     = 3'd4
  } swv_kind_e;

  typedef enum logic [1:0] {
    RegCtrl     = 2'd0,
    RegSweep    = 2'd1,
    RegPeriodLo = 2'd2,
    RegPeriodHi = 2'd3
  } swv_reg_e;

  localparam int unsigned PeriodW   = 11;
  localparam logic [PeriodW-1:0] PeriodMin = 11'd8;
  localparam logic [3:0] DecayMax  = 4'd15;

  typedef struct packed {
    logic       clock;
    logic       start;
    logic       loop;
    logic [3:0] setting;
  } env_ctl_t;

  typedef struct packed {
    logic       half;
    logic       wr_sweep;
    logic       wr_lo;
    logic       wr_hi;
    logic [7:0] data;
  } swp_ctl_t;

  function automatic logic [7:0] length_for_index(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:  val = 8'd10;   5'd1:  val = 8'd254;
      5'd2:  val = 8'd20;   5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;   5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;   5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;  5'd9:  val = 8'd8;
      5'd10: val = 8'd60;   5'd11: val = 8'd10;
      5'd12: val = 8'd14;   5'd13: val = 8'd12;
      5'd14: val = 8'd26;   5'd15: val = 8'd14;
      5'd16: val = 8'd12;   5'd17: val = 8'd16;
      5'd18: val = 8'd24;   5'd19: val = 8'd18;
      5'd20: val = 8'd48;   5'd21: val = 8'd20;
      5'd22: val = 8'd96;   5'd23: val = 8'd22;
      5'd24: val = 8'd192;  5'd25: val = 8'd24;
      5'd26: val = 8'd72;   5'd27: val = 8'd26;
      5'd28: val = 8'd16;   5'd29: val = 8'd28;
      5'd30: val = 8'd32;   5'd31: val = 8'd30;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  // bit n of the row is the output at duty step n
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] row;
    case (sel)
      2'd0:    row = 8'b0000_0010;
      2'd1:    row = 8'b0000_0110;
      2'd2:    row = 8'b0001_1110;
      2'd3:    row = 8'b1111_1001;
      default: row = 8'b0000_0000;
    endcase
    return row[step];
  endfunction

endpackage

### design/swv_env.sv
// Envelope generator: start flag, divider and decay level.
module swv_env (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swv_pkg::env_ctl_t ctl_i,
  output logic [3:0]        decay_next_o
);
  import swv_pkg::*;

  logic       start_q, start_d;
  logic [3:0] div_q, div_d;
  logic [3:0] decay_q, decay_d;

  always_comb begin
    start_d = start_q;
    div_d   = div_q;
    decay_d = decay_q;
    if (ctl_i.start) begin
      start_d = 1'b1;
    end else if (ctl_i.clock) begin
      if (start_q) begin
        start_d = 1'b0;
        decay_d = DecayMax;
        div_d   = ctl_i.setting;
      end else if (div_q == 4'd0) begin
        if (decay_q != 4'd0) begin
          decay_d = decay_q - 4'd1;
        end else if (ctl_i.loop) begin
          decay_d = DecayMax;
        end
        div_d = ctl_i.setting;
      end else begin
        div_d = div_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      div_q   <= '0;
      decay_q <= '0;
    end else begin
      start_q <= start_d;
      div_q   <= div_d;
      decay_q <= decay_d;
    end
  end

  assign decay_next_o = decay_d;

endmodule

### design/swv_sweep.sv
// Sweep unit: period register, target calculation and mute flag.
module swv_sweep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swv_pkg::swp_ctl_t              ctl_i,
  output logic [swv_pkg::PeriodW-1:0]    period_o,
  output logic                           muted_next_o
);
  import swv_pkg::*;

  logic               on_q, on_d;
  logic [2:0]         rate_q, rate_d;
  logic               down_q, down_d;
  logic [2:0]         amount_q, amount_d;
  logic               restart_q, restart_d;
  logic [2:0]         div_q, div_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic               muted_q, muted_d;

  logic [PeriodW-1:0] change;
  logic [PeriodW:0]   sum;
  logic [PeriodW-1:0] diff;
  logic [PeriodW-1:0] target;
  logic               mute_now;

  assign change   = period_q >> amount_q;
  assign sum      = {1'b0, period_q} + {1'b0, change};
  assign diff     = period_q - change;
  assign target   = down_q ? diff : sum[PeriodW-1:0];
  assign mute_now = (period_q < PeriodMin) || (!down_q && sum[PeriodW]);

  always_comb begin
    on_d      = on_q;
    rate_d    = rate_q;
    down_d    = down_q;
    amount_d  = amount_q;
    restart_d = restart_q;
    div_d     = div_q;
    period_d  = period_q;
    muted_d   = muted_q;
    if (ctl_i.wr_sweep) begin
      on_d      = ctl_i.data[7];
      rate_d    = ctl_i.data[6:4];
      down_d    = ctl_i.data[3];
      amount_d  = ctl_i.data[2:0];
      restart_d = 1'b1;
    end
    if (ctl_i.wr_lo) begin
      period_d[7:0] = ctl_i.data;
    end
    if (ctl_i.wr_hi) begin
      period_d[PeriodW-1:8] = ctl_i.data[2:0];
    end
    if (ctl_i.half) begin
      muted_d = mute_now;
      if (div_q == 3'd0 && on_q && !mute_now && amount_q != 3'd0) begin
        period_d = target;
      end
      if (div_q == 3'd0 || restart_q) begin
        div_d     = rate_q;
        restart_d = 1'b0;
      end else begin
        div_d = div_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      rate_q    <= '0;
      down_q    <= 1'b0;
      amount_q  <= '0;
      restart_q <= 1'b0;
      div_q     <= '0;
      period_q  <= '0;
      muted_q   <= 1'b0;
    end else begin
      on_q      <= on_d;
      rate_q    <= rate_d;
      down_q    <= down_d;
      amount_q  <= amount_d;
      restart_q <= restart_d;
      div_q     <= div_d;
      period_q  <= period_d;
      muted_q   <= muted_d;
    end
  end

  assign period_o     = period_q;
  assign muted_next_o = muted_d;

endmodule

### design/square_wave_voice_with_sweep_top.sv
// Square-wave voice: timer, duty sequencer, length counter, envelope and sweep.
//
// Input channel (in_valid_i / in_ready_o) carries one beat per event:
// kind_i selects a register write, enable write, timer tick, quarter-frame
// or half-frame clock; reg_index_i and data_byte_i carry the write.
// Output channel (out_valid_o / out_ready_i) returns one beat per input
// beat: level_o, the 0..15 voice level after that event.
// The voice state updates at the edge that takes the input beat; its level goes
// into the level register, or into the skid register while a level waits.
// Throughput is one beat per cycle while in_ready_o stays high.
// A two-entry output buffer (level register plus skid register) lets an
// input beat be taken while a level waits; in_ready_o drops only when both
// entries are full, i.e. after a beat was taken while the receiver stalled.
// Reset clears all voice state and empties the output buffer; the voice
// then reports level 0 until enabled and loaded.
module square_wave_voice_with_sweep_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [1:0] reg_index_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] level_o
);
  import swv_pkg::*;

  logic               in_fire, out_fire;
  swv_kind_e          kind;
  swv_reg_e           reg_sel;

  logic               voice_on_q, voice_on_d;
  logic [1:0]         duty_sel_q, duty_sel_d;
  logic [2:0]         step_q, step_d;
  logic [PeriodW-1:0] count_q, count_d;
  logic               halt_q, halt_d;
  logic [7:0]         length_q, length_d;
  logic               const_q, const_d;
  logic [3:0]         setting_q, setting_d;

  env_ctl_t           env_ctl;
  swp_ctl_t           swp_ctl;
  logic [3:0]         decay_next;
  logic [PeriodW-1:0] period;
  logic               muted_next;
  logic [3:0]         level_d;

  logic               out_valid_q, skid_valid_q;
  logic [3:0]         out_level_q, skid_level_q;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign kind       = swv_kind_e'(kind_i);
  assign reg_sel    = swv_reg_e'(reg_index_i);

  always_comb begin
    env_ctl         = '0;
    env_ctl.loop    = halt_q;
    env_ctl.setting = setting_q;
    swp_ctl         = '0;
    swp_ctl.data    = data_byte_i;
    if (in_fire) begin
      case (kind)
        KindRegWrite: begin
          env_ctl.start    = (reg_sel == RegCtrl) || (reg_sel == RegPeriodHi);
          swp_ctl.wr_sweep = (reg_sel == RegSweep);
          swp_ctl.wr_lo    = (reg_sel == RegPeriodLo);
          swp_ctl.wr_hi    = (reg_sel == RegPeriodHi);
        end
        KindQuarter: begin
          env_ctl.clock = 1'b1;
        end
        KindHalf: begin
          env_ctl.clock = 1'b1;
          swp_ctl.half  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  swv_env u_env (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (env_ctl),
    .decay_next_o (decay_next)
  );

  swv_sweep u_sweep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (swp_ctl),
    .period_o     (period),
    .muted_next_o (muted_next)
  );

  always_comb begin
    voice_on_d = voice_on_q;
    duty_sel_d = duty_sel_q;
    step_d     = step_q;
    count_d    = count_q;
    halt_d     = halt_q;
    length_d   = length_q;
    const_d    = const_q;
    setting_d  = setting_q;
    if (in_fire) begin
      case (kind)
        KindRegWrite: begin
          if (reg_sel == RegCtrl) begin
            duty_sel_d = data_byte_i[7:6];
            halt_d     = data_byte_i[5];
            const_d    = data_byte_i[4];
            setting_d  = data_byte_i[3:0];
          end else if (reg_sel == RegPeriodHi) begin
            step_d   = '0;
            length_d = length_for_index(data_byte_i[7:3]);
          end
        end
        KindEnable: begin
          voice_on_d = data_byte_i[0];
          if (!data_byte_i[0]) begin
            length_d = '0;
          end
        end
        KindTick: begin
          if (count_q == '0) begin
            count_d = period;
            step_d  = step_q + 3'd1;
          end else begin
            count_d = count_q - PeriodW'(1);
          end
        end
        KindHalf: begin
          if (!halt_q && length_q != 8'd0) begin
            length_d = length_q - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (!voice_on_d || muted_next || length_d == 8'd0 || !duty_bit(duty_sel_d, step_d)) begin
      level_d = 4'd0;
    end else begin
      level_d = const_d ? setting_d : decay_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_on_q <= 1'b0;
      duty_sel_q <= '0;
      step_q     <= '0;
      count_q    <= '0;
      halt_q     <= 1'b0;
      length_q   <= '0;
      const_q    <= 1'b0;
      setting_q  <= '0;
    end else begin
      voice_on_q <= voice_on_d;
      duty_sel_q <= duty_sel_d;
      step_q     <= step_d;
      count_q    <= count_d;
      halt_q     <= halt_d;
      length_q   <= length_d;
      const_q    <= const_d;
      setting_q  <= setting_d;
    end
  end

  // output buffer: level register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= in_fire;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_level_q  <= skid_level_q;
        skid_level_q <= level_d;
      end else begin
        out_level_q <= level_d;
      end
    end else if (in_fire) begin
      skid_level_q <= level_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty level register");

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_disable_clears_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && kind_i == KindEnable && !data_byte_i[0] |=> length_q == 8'd0)
    else $error("disable left length count nonzero");

  a_no_loss_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && skid_valid_q |=> skid_valid_q && out_valid_q)
    else $error("buffered level dropped during stall");

endmodule
